// File: rtl/rlc_pkg.sv
// Shared types, opcodes and helpers for the one-lane RV32I step core.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none
package rlc_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int MAX_STEPS_DEF = 1000000;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_STEP  = 2'd3;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_HALT  = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] INSN_EBREAK = 32'h00100073;
  localparam logic [11:0] CSR_MHARTID = 12'hf14;
  localparam logic [6:0]  F7_ZERO     = 7'h00;
  localparam logic [6:0]  F7_ALT      = 7'h20;

  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_HALF = 3'd2;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HREAD,
    S_DECODE,
    S_EXEC,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic        en;
    logic        we;
    logic [31:0] addr;
    logic [2:0]  size;
    logic [31:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic        fault;
    logic        halt;
    logic        is_load;
    logic        is_store;
    logic        rd_we;
    logic [31:0] rd_val;
    logic [31:0] pc_next;
    logic [31:0] mem_addr;
    logic [2:0]  mem_size;
    logic [31:0] store_data;
  } exec_res_t;

  // True when every byte of the access lies below the memory size.
  function automatic logic in_range(input logic [31:0] addr, input logic [2:0] size,
                                    input logic [32:0] mem_bytes);
    in_range = ({1'b0, addr} + {30'd0, size}) <= mem_bytes;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rlc_mem.sv
// Byte-addressed little-endian data memory built from four byte-wide banks.
// Depends on rlc_pkg; misaligned words are spread over two rows of the banks.
`timescale 1ns / 1ps
`default_nettype none
module rlc_mem import rlc_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire mem_req_t    req,
  output logic [31:0]      rdata
);

  localparam int ROWS = (MEM_BYTES + 3) / 4;
  localparam int RW   = $clog2(ROWS);

  logic [1:0]          off;
  logic [1:0]          off_q;
  logic [3:0][RW-1:0]  row;
  logic [3:0][7:0]     bank_wd;
  logic [3:0]          bank_we;
  logic [3:0][7:0]     bank_rd;

  assign off = req.addr[1:0];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      // Byte index of the access that lands in bank b.
      logic [1:0] idx;
      idx        = 2'(b) - off;
      row[b]     = req.addr[RW+1:2] + RW'((2'(b) < off) ? 1 : 0);
      bank_wd[b] = req.wdata[8*idx +: 8];
      bank_we[b] = req.en && req.we && ({1'b0, idx} < req.size);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] ram [ROWS];
    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        ram[row[b]] <= bank_wd[b];
      end
      if (req.en && !req.we) begin
        bank_rd[b] <= ram[row[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.en && !req.we) begin
      off_q <= off;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata[8*i +: 8] = bank_rd[2'(i) + off_q];
    end
  end

endmodule
`default_nettype wire

// File: rtl/rlc_regfile.sv
// Integer register file: 32 words with two registered read ports and one write.
// Depends on rlc_pkg; valid bits make unwritten or cleared entries read as zero.
`timescale 1ns / 1ps
`default_nettype none
module rlc_regfile import rlc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        clr,
  input  wire logic [4:0]  ra1,
  input  wire logic [4:0]  ra2,
  input  wire logic        we,
  input  wire logic [4:0]  wa,
  input  wire logic [31:0] wd,
  output logic [31:0]      rd1,
  output logic [31:0]      rd2
);

  logic [31:0] ram [32];
  logic [31:0] valid;
  logic [31:0] q1;
  logic [31:0] q2;
  logic        v1;
  logic        v2;

  always_ff @(posedge clk) begin
    if (we) begin
      ram[wa] <= wd;
    end
    q1 <= ram[ra1];
    q2 <= ram[ra2];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      if (we) begin
        valid[wa] <= 1'b1;
      end
      v1 <= valid[ra1];
      v2 <= valid[ra2];
    end
  end

  assign rd1 = v1 ? q1 : 32'd0;
  assign rd2 = v2 ? q2 : 32'd0;

endmodule
`default_nettype wire

// File: rtl/rlc_exec.sv
// Decode and execute of one instruction from its word, pc and operands.
// Depends on rlc_pkg; gives register write, next pc, memory access and fault.
`timescale 1ns / 1ps
`default_nettype none
module rlc_exec import rlc_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic [31:0] insn,
  input  wire logic [31:0] pc,
  input  wire logic [31:0] v1,
  input  wire logic [31:0] v2,
  input  wire logic [31:0] hart,
  output exec_res_t        res
);

  localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  sh;
  logic [31:0] immi;
  logic [31:0] ims;
  logic [31:0] immj;
  logic [31:0] immb;
  logic [31:0] pc4;
  logic [31:0] r;
  logic        wr;
  logic        bad;
  logic        take;
  logic [2:0]  msize;

  assign op   = insn[6:0];
  assign rd   = insn[11:7];
  assign f3   = insn[14:12];
  assign f7   = insn[31:25];
  assign sh   = insn[24:20];
  assign immi = {{20{insn[31]}}, insn[31:20]};
  assign ims  = {{20{insn[31]}}, insn[31:25], insn[11:7]};
  assign immj = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
  assign immb = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
  assign pc4  = pc + 32'd4;

  always_comb begin
    r     = 32'd0;
    wr    = 1'b0;
    bad   = 1'b0;
    take  = 1'b0;
    msize = SIZE_WORD;
    res   = '0;
    res.pc_next = pc4;
    unique case (f3)
      3'd0:    msize = SIZE_BYTE;
      3'd1:    msize = SIZE_HALF;
      default: msize = SIZE_WORD;
    endcase
    if (insn == INSN_EBREAK) begin
      res.halt = 1'b1;
    end else begin
      unique case (op)
        OP_REG: begin
          wr = 1'b1;
          priority if (f3 == 3'd0 && f7 == F7_ZERO) r = v1 + v2;
          else if (f3 == 3'd0 && f7 == F7_ALT)  r = v1 - v2;
          else if (f3 == 3'd7 && f7 == F7_ZERO) r = v1 & v2;
          else if (f3 == 3'd6 && f7 == F7_ZERO) r = v1 | v2;
          else if (f3 == 3'd4 && f7 == F7_ZERO) r = v1 ^ v2;
          else if (f3 == 3'd1 && f7 == F7_ZERO) r = v1 << v2[4:0];
          else if (f3 == 3'd5 && f7 == F7_ZERO) r = v1 >> v2[4:0];
          else if (f3 == 3'd5 && f7 == F7_ALT)  r = 32'($signed(v1) >>> v2[4:0]);
          else bad = 1'b1;
        end
        OP_IMM: begin
          wr = 1'b1;
          unique case (f3)
            3'd0: r = v1 + immi;
            3'd1: r = v1 << sh;
            3'd2: r = {31'd0, $signed(v1) < $signed(immi)};
            3'd3: r = {31'd0, v1 < immi};
            3'd4: r = v1 ^ immi;
            3'd5: r = insn[30] ? 32'($signed(v1) >>> sh) : (v1 >> sh);
            3'd6: r = v1 | immi;
            3'd7: r = v1 & immi;
            default: r = 32'd0;
          endcase
        end
        OP_LOAD: begin
          res.mem_addr = v1 + immi;
          res.mem_size = msize;
          if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2) begin
            bad = !in_range(res.mem_addr, msize, MEM_LIMIT);
          end else begin
            bad = 1'b1;
          end
          res.is_load = !bad;
        end
        OP_STORE: begin
          res.mem_addr   = v1 + ims;
          res.mem_size   = msize;
          res.store_data = v2;
          if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2) begin
            bad = !in_range(res.mem_addr, msize, MEM_LIMIT);
          end else begin
            bad = 1'b1;
          end
          res.is_store = !bad;
        end
        OP_LUI: begin
          wr = 1'b1;
          r  = {insn[31:12], 12'd0};
        end
        OP_AUIPC: begin
          wr = 1'b1;
          r  = pc + {insn[31:12], 12'd0};
        end
        OP_JAL: begin
          wr = 1'b1;
          r  = pc4;
          res.pc_next = pc + immj;
        end
        OP_JALR: begin
          wr = 1'b1;
          r  = pc4;
          res.pc_next = (v1 + immi) & ~32'd1;
        end
        OP_BRANCH: begin
          unique case (f3)
            3'd0: take = v1 == v2;
            3'd1: take = v1 != v2;
            3'd4: take = $signed(v1) < $signed(v2);
            3'd5: take = $signed(v1) >= $signed(v2);
            3'd6: take = v1 < v2;
            3'd7: take = v1 >= v2;
            default: bad = 1'b1;
          endcase
          if (take) begin
            res.pc_next = pc + immb;
          end
        end
        OP_SYSTEM: begin
          if (insn[31:20] == CSR_MHARTID && f3 == 3'd2) begin
            wr = 1'b1;
            r  = hart;
          end else begin
            bad = 1'b1;
          end
        end
        default: bad = 1'b1;
      endcase
    end
    res.fault  = bad;
    res.rd_we  = wr && !bad && (rd != 5'd0);
    res.rd_val = r;
  end

endmodule
`default_nettype wire

// File: rtl/rv32i_lane_core_step.sv
// One-lane RV32I-subset core with private byte memory; one request at a time.
// Writes and starts complete on acceptance; a memory read passes the host-read state; a step
// runs fetch, register read and execute, and a load step adds a load state. A new request
// is taken only when idle and no result is held waiting by the receiver.
// Synchronous reset clears lane state, entry pc and register file valid bits.
`timescale 1ns / 1ps
`default_nettype none
module rv32i_lane_core_step import rlc_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [13:0] word_address,
  input  wire logic [31:0] write_data,
  input  wire logic [31:0] hart_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      read_data,
  output logic [1:0]       lane_status,
  output logic [31:0]      current_pc,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int          CW        = $clog2(MAX_STEPS + 1);
  localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

  state_t      state_q;
  state_t      state_next;
  logic [1:0]  run_q;
  logic [31:0] pc_q;
  logic [CW-1:0] cnt_q;
  logic [31:0] hart_q;
  logic [15:0] entry_q;
  logic [31:0] insn_q;
  logic [31:0] rdata_q;
  logic        hok_q;

  logic        accept;
  logic [31:0] haddr;
  logic        h_ok;
  logic        fetch_ok;
  logic        step_go;
  logic        done;
  mem_req_t    mem_req;
  logic [31:0] mem_rdata;
  logic [31:0] v1;
  logic [31:0] v2;
  exec_res_t   ex;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic [31:0] ld_val;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = !((state_q == S_IDLE) && (!out_valid || !out_stall));
  assign cfg_ready = 1'b1;
  assign haddr     = {16'd0, word_address, 2'b00};
  assign h_ok      = in_range(haddr, SIZE_WORD, MEM_LIMIT);
  assign fetch_ok  = in_range(pc_q, SIZE_WORD, MEM_LIMIT);
  assign step_go   = accept && (mode == MODE_STEP) && (run_q == ST_RUN)
                     && (cnt_q < CW'(MAX_STEPS)) && fetch_ok;

  rlc_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  rlc_regfile u_rf (
    .clk (clk),
    .rst (rst),
    .clr (accept && (mode == MODE_START)),
    .ra1 (mem_rdata[19:15]),
    .ra2 (mem_rdata[24:20]),
    .we  (rf_we),
    .wa  (rf_wa),
    .wd  (rf_wd),
    .rd1 (v1),
    .rd2 (v2)
  );

  rlc_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
    .insn (insn_q),
    .pc   (pc_q),
    .v1   (v1),
    .v2   (v2),
    .hart (hart_q),
    .res  (ex)
  );

  // Memory port: host requests and instruction fetch from idle, data access
  // from execute. Only one request is in flight, so the two never collide.
  always_comb begin
    mem_req = '0;
    priority if (accept) begin
      mem_req.addr  = haddr;
      mem_req.size  = SIZE_WORD;
      mem_req.wdata = write_data;
      unique case (mode)
        MODE_WRITE: begin
          mem_req.en = h_ok;
          mem_req.we = 1'b1;
        end
        MODE_READ:  mem_req.en = 1'b1;
        MODE_STEP: begin
          mem_req.en   = step_go;
          mem_req.addr = pc_q;
        end
        default:    mem_req.en = 1'b0;
      endcase
    end else if (state_q == S_EXEC && (ex.is_store || ex.is_load)) begin
      mem_req.en    = 1'b1;
      mem_req.we    = ex.is_store;
      mem_req.addr  = ex.mem_addr;
      mem_req.size  = ex.mem_size;
      mem_req.wdata = ex.store_data;
    end else begin
      mem_req.en = 1'b0;
    end
  end

  always_comb begin
    unique case (insn_q[13:12])
      2'd0:    ld_val = {{24{mem_rdata[7]}}, mem_rdata[7:0]};
      2'd1:    ld_val = {{16{mem_rdata[15]}}, mem_rdata[15:0]};
      default: ld_val = mem_rdata;
    endcase
    rf_wa = insn_q[11:7];
    if (state_q == S_LOAD) begin
      rf_we = (insn_q[11:7] != 5'd0);
      rf_wd = ld_val;
    end else begin
      rf_we = (state_q == S_EXEC) && ex.rd_we;
      rf_wd = ex.rd_val;
    end
  end

  always_comb begin
    state_next = state_q;
    done       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode == MODE_READ) begin
            state_next = S_HREAD;
          end else if (step_go) begin
            state_next = S_DECODE;
          end else begin
            done = 1'b1;
          end
        end
      end
      S_HREAD: begin
        state_next = S_IDLE;
        done       = 1'b1;
      end
      S_DECODE: state_next = S_EXEC;
      S_EXEC: begin
        if (ex.is_load) begin
          state_next = S_LOAD;
        end else begin
          state_next = S_IDLE;
          done       = 1'b1;
        end
      end
      S_LOAD: begin
        state_next = S_IDLE;
        done       = 1'b1;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_q     <= ST_IDLE;
      pc_q      <= 32'd0;
      cnt_q     <= '0;
      hart_q    <= 32'd0;
      entry_q   <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        entry_q <= cfg_data;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept && mode == MODE_START) begin
        pc_q   <= {16'd0, entry_q};
        hart_q <= hart_id;
        cnt_q  <= '0;
        run_q  <= ST_RUN;
      end else if (accept && mode == MODE_STEP && run_q == ST_RUN) begin
        if (cnt_q >= CW'(MAX_STEPS)) begin
          run_q <= ST_FAULT;
        end else begin
          cnt_q <= cnt_q + CW'(1);
          if (!fetch_ok) begin
            run_q <= ST_FAULT;
          end
        end
      end
      if (state_q == S_EXEC) begin
        if (ex.fault) begin
          run_q <= ST_FAULT;
        end else if (ex.halt) begin
          pc_q  <= pc_q + 32'd4;
          run_q <= ST_HALT;
        end else if (!ex.is_load) begin
          pc_q <= ex.pc_next;
        end
      end
      if (state_q == S_LOAD) begin
        pc_q <= pc_q + 32'd4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_q <= 32'd0;
      hok_q   <= h_ok;
    end
    if (state_q == S_HREAD) begin
      rdata_q <= hok_q ? mem_rdata : 32'd0;
    end
    if (state_q == S_DECODE) begin
      insn_q <= mem_rdata;
    end
  end

  assign read_data   = rdata_q;
  assign lane_status = run_q;
  assign current_pc  = pc_q;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_q <= CW'(MAX_STEPS))
    else $error("step count passed its limit");

  a_busy_empty: assert property (@(posedge clk) disable iff (rst)
    (state_q != S_IDLE) |-> !out_valid)
    else $error("result pending while a request is still in progress");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_STEP && run_q != ST_RUN) |=> (out_valid && $stable(pc_q)))
    else $error("step on a stopped lane changed the pc or gave no result");

endmodule
`default_nettype wire

// File: test/rv32i_lane_core_step_tb.sv
// Self-checking testbench for rv32i_lane_core_step: a directed table, a full memory fill,
// then random programs run under random idling. Depends on rlc_pkg and the core RTL.
`timescale 1ns / 1ps
module rv32i_lane_core_step_tb;
  import rlc_pkg::*;

  localparam int MEM_SIZE = 65536;
  localparam int STEP_LIMIT = 1000000;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_REQS = 2000;
  localparam int LONG_HOLD = 300;

  localparam logic [31:0] INSN_ECALL = 32'h00000073;
  localparam logic [31:0] INSN_FP = 32'h00000053;
  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
  localparam logic [2:0] F3_B = 3'd0, F3_H = 3'd1, F3_W = 3'd2, F3_CSRRS = 3'd2;

  typedef struct {
    logic [1:0]  mode;
    logic [13:0] waddr;
    logic [31:0] wdata;
    logic [31:0] hid;
    bit          typed;
    logic [31:0] rdata;
    logic [1:0]  status;
    logic [31:0] pc;
  } req_row_t;

  typedef struct {
    logic [31:0] rdata;
    logic [1:0]  status;
    logic [31:0] pc;
  } lane_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_WRITE;
  logic [13:0] word_address = '0;
  logic [31:0] write_data = '0;
  logic [31:0] hart_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] read_data;
  logic [1:0] lane_status;
  logic [31:0] current_pc;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  rv32i_lane_core_step dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .word_address(word_address), .write_data(write_data), .hart_id(hart_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .lane_status(lane_status), .current_pc(current_pc),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted lane state.
  logic [31:0] lane_regs [0:31];
  logic [7:0]  lane_mem [0:MEM_SIZE-1];
  logic [31:0] lane_pc;
  logic [31:0] lane_hart;
  logic [1:0]  lane_state;
  logic [15:0] lane_entry;
  int          lane_steps;

  lane_out_t expected_lane_out [$];
  int errors = 0;
  int burst_left = 0;
  int rand_reqs = 0;
  bit long_hold_due = 0;

  function automatic bit fits(input logic [31:0] addr, input int size);
    return ({32'd0, addr} + 64'(size)) <= 64'(MEM_SIZE);
  endfunction

  function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
    logic [31:0] t;
    t = v << (32 - bits);
    return $unsigned($signed(t) >>> (32 - bits));
  endfunction

  function automatic logic [31:0] mem_load(input logic [31:0] addr, input int size);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < size; i++) v[8*i +: 8] = lane_mem[addr + i];
    return v;
  endfunction

  function automatic void mem_store(input logic [31:0] addr, input logic [31:0] v,
                                    input int size);
    for (int i = 0; i < size; i++) lane_mem[addr + i] = v[8*i +: 8];
  endfunction

  function automatic void set_reg(input logic [4:0] rd, input logic [31:0] v);
    if (rd != 5'd0) lane_regs[rd] = v;
  endfunction

  // Executes the instruction at the lane pc; returns 0 when it faults.
  function automatic bit run_insn();
    logic [31:0] pc, insn, v1, v2, immi, ims, addr, r, imm;
    logic [6:0] op, f7;
    logic [4:0] rd, rs1, rs2, sh;
    logic [2:0] f3;
    int size;
    bit take;
    pc = lane_pc;
    if (!fits(pc, 4)) return 0;
    insn = mem_load(pc, 4);
    if (insn == INSN_EBREAK) begin
      lane_pc = pc + 4;
      lane_state = ST_HALT;
      return 1;
    end
    op = insn[6:0];
    rd = insn[11:7];
    f3 = insn[14:12];
    rs1 = insn[19:15];
    rs2 = insn[24:20];
    f7 = insn[31:25];
    sh = insn[24:20];
    v1 = lane_regs[rs1];
    v2 = lane_regs[rs2];
    immi = sx({20'd0, insn[31:20]}, 12);
    ims = sx({20'd0, insn[31:25], insn[11:7]}, 12);
    case (op)
      OP_REG: begin
        if (f3 == F3_ADD && f7 == F7_ZERO) r = v1 + v2;
        else if (f3 == F3_ADD && f7 == F7_ALT) r = v1 - v2;
        else if (f3 == F3_AND && f7 == F7_ZERO) r = v1 & v2;
        else if (f3 == F3_OR && f7 == F7_ZERO) r = v1 | v2;
        else if (f3 == F3_XOR && f7 == F7_ZERO) r = v1 ^ v2;
        else if (f3 == F3_SLL && f7 == F7_ZERO) r = v1 << v2[4:0];
        else if (f3 == F3_SR && f7 == F7_ZERO) r = v1 >> v2[4:0];
        else if (f3 == F3_SR && f7 == F7_ALT) r = $unsigned($signed(v1) >>> v2[4:0]);
        else return 0;
        set_reg(rd, r);
      end
      OP_IMM: begin
        case (f3)
          F3_ADD:  r = v1 + immi;
          F3_SLL:  r = v1 << sh;
          F3_SLT:  r = ($signed(v1) < $signed(immi)) ? 32'd1 : 32'd0;
          F3_SLTU: r = (v1 < immi) ? 32'd1 : 32'd0;
          F3_XOR:  r = v1 ^ immi;
          F3_SR:   r = insn[30] ? $unsigned($signed(v1) >>> sh) : (v1 >> sh);
          F3_OR:   r = v1 | immi;
          default: r = v1 & immi;
        endcase
        set_reg(rd, r);
      end
      OP_LOAD, OP_STORE: begin
        addr = v1 + ((op == OP_LOAD) ? immi : ims);
        case (f3)
          F3_B: size = 1;
          F3_H: size = 2;
          F3_W: size = 4;
          default: return 0;
        endcase
        if (!fits(addr, size)) return 0;
        if (op == OP_STORE) mem_store(addr, v2, size);
        else if (size == 4) set_reg(rd, mem_load(addr, 4));
        else set_reg(rd, sx(mem_load(addr, size), 8 * size));
      end
      OP_LUI: set_reg(rd, {insn[31:12], 12'd0});
      OP_AUIPC: set_reg(rd, pc + {insn[31:12], 12'd0});
      OP_JAL: begin
        imm = {11'd0, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
        set_reg(rd, pc + 4);
        lane_pc = pc + sx(imm, 21);
        return 1;
      end
      OP_JALR: begin
        r = (v1 + immi) & ~32'd1;
        set_reg(rd, pc + 4);
        lane_pc = r;
        return 1;
      end
      OP_BRANCH: begin
        imm = {19'd0, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
        case (f3)
          F3_BEQ:  take = v1 == v2;
          F3_BNE:  take = v1 != v2;
          F3_BLT:  take = $signed(v1) < $signed(v2);
          F3_BGE:  take = $signed(v1) >= $signed(v2);
          F3_BLTU: take = v1 < v2;
          F3_BGEU: take = v1 >= v2;
          default: return 0;
        endcase
        if (take) begin
          lane_pc = pc + sx(imm, 13);
          return 1;
        end
      end
      OP_SYSTEM: begin
        if (insn[31:20] == CSR_MHARTID && f3 == F3_CSRRS) set_reg(rd, lane_hart);
        else return 0;
      end
      default: return 0;
    endcase
    lane_pc = pc + 4;
    return 1;
  endfunction

  function automatic lane_out_t predict_lane(input req_row_t q);
    lane_out_t o;
    logic [31:0] baddr;
    baddr = {16'd0, q.waddr, 2'b00};
    o.rdata = '0;
    case (q.mode)
      MODE_WRITE: if (fits(baddr, 4)) mem_store(baddr, q.wdata, 4);
      MODE_READ:  if (fits(baddr, 4)) o.rdata = mem_load(baddr, 4);
      MODE_START: begin
        for (int i = 0; i < 32; i++) lane_regs[i] = '0;
        lane_pc = {16'd0, lane_entry};
        lane_hart = q.hid;
        lane_steps = 0;
        lane_state = ST_RUN;
      end
      default: begin
        if (lane_state == ST_RUN) begin
          if (lane_steps >= STEP_LIMIT) lane_state = ST_FAULT;
          else begin
            lane_steps++;
            if (!run_insn()) lane_state = ST_FAULT;
          end
        end
      end
    endcase
    o.status = lane_state;
    o.pc = lane_pc;
    return o;
  endfunction

  task automatic send_req(input req_row_t q);
    lane_out_t o;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= q.mode;
    word_address <= q.waddr;
    write_data <= q.wdata;
    hart_id <= q.hid;
    do @(posedge clk); while (in_stall);
    o = predict_lane(q);
    if (q.typed) begin
      o.rdata = q.rdata;
      o.status = q.status;
      o.pc = q.pc;
    end
    expected_lane_out.push_back(o);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_plain(input logic [1:0] m, input logic [13:0] wa,
                            input logic [31:0] wd, input logic [31:0] hid);
    req_row_t q;
    q = '{m, wa, wd, hid, 1'b0, '0, ST_IDLE, '0};
    send_req(q);
  endtask

  // Sender stops and waits until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_lane_out.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_entry(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    lane_entry = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] small_offset(input int bits);
    int off;
    off = $urandom_range(0, 32) * 2 - 32;
    return 32'(off) & ((32'd1 << bits) - 1);
  endfunction

  function automatic logic [31:0] rand_insn();
    logic [31:0] imm;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [4:0] rs1;
    logic [11:0] i12;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        f7 = ($urandom_range(0, 7) == 0) ? 7'($urandom) :
             ($urandom_range(0, 1) ? F7_ALT : F7_ZERO);
        return {f7, pick_reg(), pick_reg(), 3'($urandom), pick_reg(), OP_REG};
      end
      3, 4, 5: return {12'($urandom), pick_reg(), 3'($urandom), pick_reg(), OP_IMM};
      6, 7, 8, 9: begin
        f3 = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
        if ($urandom_range(0, 3) != 0) begin
          rs1 = 5'd0;
          i12 = 12'($urandom_range(0, 2047));
        end else begin
          rs1 = pick_reg();
          i12 = 12'($urandom);
        end
        if ($urandom_range(0, 1)) return {i12, rs1, f3, pick_reg(), OP_LOAD};
        return {i12[11:5], pick_reg(), rs1, f3, i12[4:0], OP_STORE};
      end
      10: return $urandom_range(0, 1) ? {16'($urandom_range(0, 15)), 4'd0, pick_reg(), OP_LUI}
                                      : {20'($urandom), pick_reg(), OP_LUI};
      11: return {20'($urandom), pick_reg(), OP_AUIPC};
      12: begin
        imm = small_offset(21);
        return {imm[20], imm[10:1], imm[11], imm[19:12], pick_reg(), OP_JAL};
      end
      13: return {12'($urandom_range(0, 64)), pick_reg(), 3'd0, pick_reg(), OP_JALR};
      14, 15: begin
        imm = small_offset(13);
        return {imm[12], imm[10:5], pick_reg(), pick_reg(), 3'($urandom), imm[4:1], imm[11],
                OP_BRANCH};
      end
      16: begin
        if ($urandom_range(0, 5) == 0)
          return {12'($urandom), pick_reg(), 3'($urandom), pick_reg(), OP_SYSTEM};
        return {CSR_MHARTID, pick_reg(), F3_CSRRS, pick_reg(), OP_SYSTEM};
      end
      17: return INSN_EBREAK;
      18: return INSN_ECALL;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_hart();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // Results are compared against the oldest prediction.
  always @(posedge clk) begin
    lane_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_lane_out.size() == 0) begin
        $error("result with no request outstanding: pc %h", current_pc);
        errors++;
      end else begin
        e = expected_lane_out.pop_front();
        if (read_data !== e.rdata) begin
          $error("read_data expected %h actual %h", e.rdata, read_data);
          errors++;
        end
        if (lane_status !== e.status) begin
          $error("lane_status expected %0d actual %0d", e.status, lane_status);
          errors++;
        end
        if (current_pc !== e.pc) begin
          $error("current_pc expected %h actual %h", e.pc, current_pc);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure: stretches of no stall, light and heavy stalling, one long hold.
  int stall_kind = 0;
  int stall_left = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (long_hold_due) begin
      long_hold_due = 0;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_kind = $urandom_range(0, 2);
        stall_left = $urandom_range(5, 60);
      end else begin
        stall_left--;
      end
      case (stall_kind)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rv32i_lane_core_step verification failed");
      $finish;
    end
  end

  req_row_t directed [$];

  initial begin
    logic [15:0] entry;
    int n_words, n_ops, phase, pick;
    lane_state = ST_IDLE;
    lane_pc = '0;
    lane_hart = '0;
    lane_entry = '0;
    lane_steps = 0;
    for (int i = 0; i < 32; i++) lane_regs[i] = '0;
    for (int i = 0; i < MEM_SIZE; i++) lane_mem[i] = '0;

    // Program at word 0: addi x1,x0,-1; csrrs x2,mhartid; sw x1,0x40(x0); ebreak.
    directed = '{
      '{MODE_STEP,  14'd0,     32'h0,        32'h0,        1, 32'h0, ST_IDLE, 32'd0},
      '{MODE_WRITE, 14'd0,     32'hfff00093, 32'h0,        1, 32'h0, ST_IDLE, 32'd0},
      '{MODE_WRITE, 14'd1,     32'hf1402173, 32'h0,        1, 32'h0, ST_IDLE, 32'd0},
      '{MODE_WRITE, 14'd2,     32'h04102023, 32'h0,        1, 32'h0, ST_IDLE, 32'd0},
      '{MODE_WRITE, 14'd3,     INSN_EBREAK,  32'h0,        1, 32'h0, ST_IDLE, 32'd0},
      '{MODE_WRITE, 14'd16383, 32'hffffffff, 32'hffffffff, 1, 32'h0, ST_IDLE, 32'd0},
      '{MODE_READ,  14'd16383, 32'h0,        32'h0,  1, 32'hffffffff, ST_IDLE, 32'd0},
      '{MODE_START, 14'd0,     32'h0,        32'hffffffff, 1, 32'h0, ST_RUN,  32'd0},
      '{MODE_STEP,  14'd0,     32'h0,        32'h0,        1, 32'h0, ST_RUN,  32'd4},
      '{MODE_STEP,  14'd0,     32'h0,        32'h0,        1, 32'h0, ST_RUN,  32'd8},
      '{MODE_STEP,  14'd0,     32'h0,        32'h0,        1, 32'h0, ST_RUN,  32'd12},
      '{MODE_STEP,  14'd0,     32'h0,        32'h0,        1, 32'h0, ST_HALT, 32'd16},
      '{MODE_STEP,  14'd0,     32'h0,        32'h0,        1, 32'h0, ST_HALT, 32'd16},
      '{MODE_READ,  14'd16,    32'h0,        32'h0,  1, 32'hffffffff, ST_HALT, 32'd16},
      '{MODE_WRITE, 14'd0,     INSN_ECALL,   32'h0,        1, 32'h0, ST_HALT, 32'd16},
      '{MODE_START, 14'd0,     32'h0,        32'h0,        1, 32'h0, ST_RUN,  32'd0},
      '{MODE_STEP,  14'd0,     32'h0,        32'h0,        1, 32'h0, ST_FAULT, 32'd0},
      '{MODE_STEP,  14'd0,     32'h0,        32'h0,        1, 32'h0, ST_FAULT, 32'd0},
      '{MODE_WRITE, 14'd0,     INSN_FP,      32'h0,        1, 32'h0, ST_FAULT, 32'd0},
      '{MODE_START, 14'd0,     32'h0,        32'h12345678, 1, 32'h0, ST_RUN,  32'd0},
      '{MODE_STEP,  14'd0,     32'h0,        32'h0,        1, 32'h0, ST_FAULT, 32'd0},
      '{MODE_WRITE, 14'd0,     32'h0,        32'h0,        1, 32'h0, ST_FAULT, 32'd0},
      '{MODE_START, 14'd0,     32'h0,        32'h0,        1, 32'h0, ST_RUN,  32'd0},
      '{MODE_STEP,  14'd0,     32'h0,        32'h0,        1, 32'h0, ST_FAULT, 32'd0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_req(directed[i]);

    // Every word is written once so that no fetch or load can see an unwritten byte.
    for (int w = 0; w < MEM_SIZE / 4; w++) send_plain(MODE_WRITE, 14'(w), $urandom, $urandom);

    phase = 0;
    while (rand_reqs < RANDOM_REQS) begin
      case (phase)
        0: entry = 16'd65532;
        1: entry = 16'd0;
        default: entry = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65532))
                                                     : 16'($urandom_range(0, 16383) * 4);
      endcase
      drain();
      write_entry(entry);
      if (phase == 3) long_hold_due = 1;
      n_words = $urandom_range(4, 24);
      for (int i = 0; i < n_words; i++) begin
        if ((entry >> 2) + i <= 16383) begin
          send_plain(MODE_WRITE, 14'((entry >> 2) + i), rand_insn(), $urandom);
          rand_reqs++;
        end
      end
      send_plain(MODE_START, 14'($urandom), $urandom, rand_hart());
      n_ops = $urandom_range(10, 60);
      for (int i = 0; i < n_ops; i++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          send_plain(MODE_READ, 14'($urandom), $urandom, $urandom);
        end else if (pick == 1) begin
          send_plain(MODE_WRITE, 14'($urandom), $urandom, $urandom);
        end else if (pick == 2) begin
          send_plain(MODE_START, 14'($urandom), $urandom, rand_hart());
        end else begin
          send_plain(MODE_STEP, 14'($urandom), $urandom, $urandom);
        end
        rand_reqs++;
      end
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("rv32i_lane_core_step verification clean");
    end else begin
      $display("rv32i_lane_core_step verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rlc_pkg.sv
rtl/rlc_mem.sv
rtl/rlc_regfile.sv
rtl/rlc_exec.sv
rtl/rv32i_lane_core_step.sv
test/rv32i_lane_core_step_tb.sv
